@@ design/i2cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Types and constants shared by the I2C bit-bang master files.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned TICK_W = HALF_W + 1;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd31;

  // command codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_ACK   = 3'd4,
    MODE_NACK  = 3'd5,
    MODE_RACK  = 3'd6
  } mode_t;

  // sequencer state: idle or the command being run
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STOP,
    ST_WRITE,
    ST_READ,
    ST_ACK,
    ST_NACK,
    ST_RACK
  } state_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } res_t;

endpackage

`default_nettype wire

@@ design/i2cbb_if.sv @@
// ----------------------------------------------------------------------------
// i2cbb_in_if / i2cbb_out_if
// Valid/ready channels for tick items and pin results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output cmd_valid, output mode, output tx_byte,
                  output sda_in, input ready);
  modport sink (input valid, input cmd_valid, input mode, input tx_byte,
                input sda_in, output ready);
endinterface

interface i2cbb_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_oe;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_ok;

  modport source (output valid, output scl, output sda_out, output sda_oe,
                  output busy_res, output done_res, output rx_byte,
                  output ack_ok, input ready);
  modport sink (input valid, input scl, input sda_out, input sda_oe,
                input busy_res, input done_res, input rx_byte, input ack_ok,
                output ready);
endinterface

`default_nettype wire

@@ design/i2cbb_engine.sv @@
// ----------------------------------------------------------------------------
// i2cbb_engine
// Bus sequencer: phase timing, pin levels, shift register and ack flag.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire i2cbb_pkg::item_t           item,
  input  wire logic [i2cbb_pkg::HALF_W-1:0] half_ticks,
  output i2cbb_pkg::res_t                 result
);
  import i2cbb_pkg::*;

  state_t            state, state_next;
  logic [1:0]        sub, sub_next;
  logic [2:0]        bit_idx, bit_idx_next;
  logic [TICK_W-1:0] tick, tick_next;
  logic [7:0]        shift, shift_next;
  logic              scl_level, scl_level_next;
  logic              sda_level, sda_level_next;
  logic              sda_enable, sda_enable_next;
  logic              ack_flag, ack_flag_next;

  state_t            cur;
  logic [1:0]        sub_c;
  logic [2:0]        bit_c;
  logic [TICK_W-1:0] tick_c, tick_inc, dur;
  logic [HALF_W-1:0] h;
  logic              scl_c, sda_c, oe_c;
  logic              last, sample, rel, busy, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sub        <= '0;
      bit_idx    <= '0;
      tick       <= '0;
      shift      <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      sda_enable <= 1'b1;
      ack_flag   <= 1'b0;
    end else if (step) begin
      state      <= state_next;
      sub        <= sub_next;
      bit_idx    <= bit_idx_next;
      tick       <= tick_next;
      shift      <= shift_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      sda_enable <= sda_enable_next;
      ack_flag   <= ack_flag_next;
    end
  end

  assign h        = (half_ticks == '0) ? HALF_W'(1) : half_ticks;
  assign tick_inc = tick_c + TICK_W'(1);

  always_comb begin
    cur        = state;
    sub_c      = sub;
    bit_c      = bit_idx;
    tick_c     = tick;
    shift_next = shift;
    ack_flag_next = ack_flag;

    // a command is taken only while idle
    if (state == ST_IDLE && item.cmd_valid) begin
      case (item.mode)
        MODE_START: cur = ST_START;
        MODE_STOP:  cur = ST_STOP;
        MODE_WRITE: begin
          cur        = ST_WRITE;
          shift_next = item.tx_byte;
        end
        MODE_READ: begin
          cur        = ST_READ;
          shift_next = '0;
        end
        MODE_ACK:   cur = ST_ACK;
        MODE_NACK:  cur = ST_NACK;
        MODE_RACK:  cur = ST_RACK;
        default:    cur = ST_IDLE;
      endcase
      sub_c  = '0;
      bit_c  = '0;
      tick_c = '0;
    end

    scl_c  = scl_level;
    sda_c  = sda_level;
    oe_c   = sda_enable;
    dur    = {1'b0, h};
    last   = 1'b0;
    sample = 1'b0;
    rel    = 1'b0;
    busy   = 1'b1;

    unique case (cur)
      ST_IDLE: busy = 1'b0;
      ST_START: begin
        scl_c = (sub_c != 2'd2);
        sda_c = (sub_c == 2'd0);
        oe_c  = 1'b1;
        last  = (sub_c == 2'd2);
      end
      ST_STOP: begin
        scl_c = (sub_c != 2'd0);
        sda_c = (sub_c == 2'd2);
        oe_c  = 1'b1;
        last  = (sub_c == 2'd2);
      end
      ST_WRITE, ST_ACK, ST_NACK: begin
        scl_c = (sub_c == 2'd1);
        if (sub_c == 2'd1) dur = {h, 1'b0};
        // msb first: bit index counts up, so select the inverted index
        if (cur == ST_WRITE) sda_c = shift_next[~bit_c];
        else sda_c = (cur == ST_NACK);
        oe_c = 1'b1;
        last = (sub_c == 2'd2) && ((cur != ST_WRITE) || (bit_c == 3'd7));
      end
      ST_READ, ST_RACK: begin
        scl_c  = (sub_c == 2'd1) || (sub_c == 2'd2);
        sda_c  = 1'b0;
        oe_c   = 1'b0;
        sample = (sub_c == 2'd1);
        rel    = 1'b1;
        last   = (sub_c == 2'd3) && ((cur != ST_READ) || (bit_c == 3'd7));
      end
      default: busy = 1'b0;
    endcase

    state_next      = cur;
    sub_next        = sub_c;
    bit_idx_next    = bit_c;
    tick_next       = tick_c;
    scl_level_next  = scl_c;
    sda_level_next  = sda_c;
    sda_enable_next = oe_c;
    done            = 1'b0;

    if (busy) begin
      tick_next = tick_inc;
      if (tick_inc >= dur) begin
        tick_next = '0;
        if (sample) begin
          if (cur == ST_READ) shift_next = {shift_next[6:0], item.sda_in};
          else ack_flag_next = ~item.sda_in;
        end
        if (last) begin
          state_next   = ST_IDLE;
          sub_next     = '0;
          bit_idx_next = '0;
          done         = 1'b1;
          // after a read or an ack read the line is driven low again
          if (rel) begin
            sda_enable_next = 1'b1;
            sda_level_next  = 1'b0;
          end
        end else if ((cur == ST_WRITE || cur == ST_ACK || cur == ST_NACK)
                     && sub_c == 2'd2) begin
          sub_next     = '0;
          bit_idx_next = bit_c + 3'd1;
        end else if (rel && sub_c == 2'd3) begin
          sub_next     = '0;
          bit_idx_next = bit_c + 3'd1;
        end else begin
          sub_next = sub_c + 2'd1;
        end
      end
    end

    result.scl      = scl_c;
    result.sda_out  = sda_c;
    result.sda_oe   = oe_c;
    result.busy_res = busy;
    result.done_res = done;
    result.rx_byte  = shift_next;
    result.ack_ok   = ack_flag_next;
  end

endmodule

`default_nettype wire

@@ design/i2c_bit_bang_master.sv @@
// ----------------------------------------------------------------------------
// i2c_bit_bang_master
// I2C master driven one clock tick per item, yielding pin levels and status.
// ----------------------------------------------------------------------------
//  channel  dir   handshake    carries
//  cmd      in    valid/ready  cmd_valid, mode, tx_byte, sda_in
//  res      out   valid/ready  scl, sda_out, sda_oe, busy_res, done_res,
//                              rx_byte, ack_ok
//  cfg      in    cfg_we       half_ticks
//
//  one item per cycle while res does not stall; an item is held in the input
//  register, then stepped through the sequencer into the result register
//  a stall on res holds both registers and drops cmd.ready in the same cycle
//  reset leaves the bus idle with both lines high and half_ticks at 31
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_bang_master (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [i2cbb_pkg::HALF_W-1:0] cfg_wdata,
  i2cbb_in_if.sink                         cmd,
  i2cbb_out_if.source                      res
);
  import i2cbb_pkg::*;

  logic              in_valid;
  item_t             in_item;
  logic              out_valid;
  res_t              out_res;
  res_t              step_res;
  logic              adv;
  logic [HALF_W-1:0] half_ticks;

  assign adv       = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) half_ticks <= HALF_RESET;
    else if (cfg_we) half_ticks <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item <= '{cmd_valid: cmd.cmd_valid, mode: cmd.mode,
                   tx_byte: cmd.tx_byte, sda_in: cmd.sda_in};
    end
  end

  i2cbb_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .item       (in_item),
    .half_ticks (half_ticks),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res <= step_res;
  end

  assign res.valid    = out_valid;
  assign res.scl      = out_res.scl;
  assign res.sda_out  = out_res.sda_out;
  assign res.sda_oe   = out_res.sda_oe;
  assign res.busy_res = out_res.busy_res;
  assign res.done_res = out_res.done_res;
  assign res.rx_byte  = out_res.rx_byte;
  assign res.ack_ok   = out_res.ack_ok;

endmodule

`default_nettype wire

@@ verif/i2cbb_checker.sv @@
// ----------------------------------------------------------------------------
// i2cbb_checker
// Watches the tick and pin channels of the I2C bit-bang master, works out the
// pin levels and status each accepted tick should give and compares them with
// the results in order of arrival.
// ----------------------------------------------------------------------------
module i2cbb_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [i2cbb_pkg::HALF_W-1:0] cfg_wdata,
  i2cbb_in_if                         cmd,
  i2cbb_out_if                        res,
  output logic                        seq_busy,
  output int                          pending,
  output int                          mismatches
);
  import i2cbb_pkg::*;

  logic [HALF_W-1:0] half_q;
  mode_t             cur_cmd;
  logic              seq_on;
  logic [5:0]        phase;
  logic [TICK_W-1:0] ticks;
  logic [7:0]        shreg;
  logic              scl_q;
  logic              sda_q;
  logic              oe_q;
  logic              ack_q;
  res_t              pins_due[$];

  // advances the bus sequencer by one tick and returns the pins it shows
  function automatic res_t pins_for_tick(item_t it);
    res_t              r;
    logic [TICK_W-1:0] h;
    logic [TICK_W-1:0] dur;
    int                last;
    int                sub;
    int                bitpos;
    logic              sample;
    logic              rel;
    r = '0;
    if (!seq_on && it.cmd_valid && it.mode != 3'd7) begin
      seq_on  = 1'b1;
      cur_cmd = mode_t'(it.mode);
      phase   = '0;
      ticks   = '0;
      if (cur_cmd == MODE_WRITE) shreg = it.tx_byte;
      else if (cur_cmd == MODE_READ) shreg = '0;
    end
    if (seq_on) begin
      h      = (half_q == '0) ? TICK_W'(1) : TICK_W'(half_q);
      dur    = h;
      last   = 0;
      sample = 1'b0;
      rel    = 1'b0;
      case (cur_cmd)
        MODE_START: begin
          last  = 2;
          scl_q = (phase != 6'd2);
          sda_q = (phase == 6'd0);
          oe_q  = 1'b1;
        end
        MODE_STOP: begin
          last  = 2;
          scl_q = (phase != 6'd0);
          sda_q = (phase == 6'd2);
          oe_q  = 1'b1;
        end
        MODE_WRITE, MODE_ACK, MODE_NACK: begin
          sub   = int'(phase) % 3;
          last  = (cur_cmd == MODE_WRITE) ? 23 : 2;
          scl_q = (sub == 1);
          // clock high is held for a full period on driven bits
          if (sub == 1) dur = h << 1;
          if (cur_cmd == MODE_WRITE) begin
            bitpos = 7 - int'(phase) / 3;
            sda_q  = shreg[bitpos];
          end else begin
            sda_q = (cur_cmd == MODE_NACK);
          end
          oe_q = 1'b1;
        end
        MODE_READ, MODE_RACK: begin
          sub    = int'(phase[1:0]);
          last   = (cur_cmd == MODE_READ) ? 31 : 3;
          scl_q  = (sub == 1 || sub == 2);
          sda_q  = 1'b0;
          oe_q   = 1'b0;
          sample = (sub == 1);
          rel    = 1'b1;
        end
        default: last = 0;
      endcase
      r.scl     = scl_q;
      r.sda_out = sda_q;
      r.sda_oe  = oe_q;
      r.busy_res = 1'b1;
      ticks = ticks + 1'b1;
      if (ticks >= dur) begin
        ticks = '0;
        if (sample) begin
          if (cur_cmd == MODE_READ) shreg = {shreg[6:0], it.sda_in};
          else ack_q = ~it.sda_in;
        end
        if (int'(phase) >= last) begin
          seq_on     = 1'b0;
          r.done_res = 1'b1;
          phase      = '0;
          // data line is taken back and driven low after a sampled command
          if (rel) begin
            oe_q  = 1'b1;
            sda_q = 1'b0;
          end
        end else begin
          phase = phase + 1'b1;
        end
      end
    end else begin
      r.scl     = scl_q;
      r.sda_out = sda_q;
      r.sda_oe  = oe_q;
    end
    r.rx_byte = shreg;
    r.ack_ok  = ack_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    item_t it;
    res_t  want;
    res_t  got;
    if (rst) begin
      half_q     = HALF_RESET;
      cur_cmd    = MODE_START;
      seq_on     = 1'b0;
      phase      = '0;
      ticks      = '0;
      shreg      = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      oe_q       = 1'b1;
      ack_q      = 1'b0;
      mismatches = 0;
      pins_due.delete();
    end else begin
      if (cfg_we) half_q = cfg_wdata;
      if (cmd.valid && cmd.ready) begin
        it = {cmd.cmd_valid, cmd.mode, cmd.tx_byte, cmd.sda_in};
        pins_due.push_back(pins_for_tick(it));
      end
      if (res.valid && res.ready) begin
        got = {res.scl, res.sda_out, res.sda_oe, res.busy_res, res.done_res,
               res.rx_byte, res.ack_ok};
        if (pins_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: pin item with nothing expected, got %0h", $time, got);
        end else begin
          want = pins_due.pop_front();
          check_field("scl", want.scl, got.scl);
          check_field("sda_out", want.sda_out, got.sda_out);
          check_field("sda_oe", want.sda_oe, got.sda_oe);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_ok", want.ack_ok, got.ack_ok);
        end
      end
    end
    seq_busy = seq_on;
    pending  = pins_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the I2C bit-bang master with tick items: a directed pass over every
// command and data extreme, opening at the reset half period, then random bus
// transfers at several half periods including zero, with bursty input and a
// stalling result side. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cbb_pkg::*;

  // how the sampled data line is driven
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RAND   = 2;
  localparam int SDA_ACKLOW = 3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [HALF_W-1:0] cfg_wdata;
  logic              seq_busy;
  int                pending;
  int                mismatches;
  int                sda_kind;
  int                burst_left;
  int                ticks_sent;

  i2cbb_in_if  cmd_ch ();
  i2cbb_out_if res_ch ();

  i2c_bit_bang_master dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  i2cbb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .seq_busy   (seq_busy),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall patterns, one long hold-off while items pile up
  initial begin
    int         cyc;
    int         hold_left;
    logic [7:0] mask;
    res_ch.ready = 1'b0;
    cyc          = 0;
    hold_left    = 0;
    mask         = 8'hFF;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 300) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (cyc % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: mask = 8'hFF;
            1: mask = 8'($urandom);
            2: mask = 8'h55;
            default: mask = 8'hF1;
          endcase
        end
        res_ch.ready <= mask[cyc % 8];
      end
    end
  end

  function automatic logic pick_sda();
    case (sda_kind)
      SDA_LOW:    return 1'b0;
      SDA_HIGH:   return 1'b1;
      SDA_ACKLOW: return ($urandom_range(0, 3) == 0);
      default:    return 1'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic cv, input logic [2:0] md, input logic [7:0] tx);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd_valid <= cv;
    cmd_ch.mode      <= md;
    cmd_ch.tx_byte   <= tx;
    cmd_ch.sda_in    <= pick_sda();
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  // clock the running sequence, throwing in commands it must ignore
  task automatic fill_while_busy();
    while (seq_busy)
      send_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic bus_cmd(input logic [2:0] md, input logic [7:0] tx);
    fill_while_busy();
    send_tick(1'b1, md, tx);
  endtask

  task automatic set_half_ticks(input logic [HALF_W-1:0] v);
    fill_while_busy();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one transfer: start, address, ack, some data bytes, stop; sometimes broken
  task automatic bus_transfer();
    int n;
    sda_kind = SDA_RAND;
    if ($urandom_range(0, 9) != 0) bus_cmd(MODE_START, 8'($urandom));
    bus_cmd(MODE_WRITE, 8'($urandom));
    sda_kind = ($urandom_range(0, 3) != 0) ? SDA_ACKLOW : SDA_RAND;
    bus_cmd(MODE_RACK, 8'($urandom));
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          sda_kind = SDA_RAND;
          bus_cmd(MODE_WRITE, 8'($urandom));
          sda_kind = SDA_ACKLOW;
          bus_cmd(MODE_RACK, 8'($urandom));
        end
        2: begin
          sda_kind = SDA_RAND;
          bus_cmd(MODE_READ, 8'($urandom));
          bus_cmd($urandom_range(0, 1) ? MODE_ACK : MODE_NACK, 8'($urandom));
        end
        default: begin
          sda_kind = SDA_RAND;
          bus_cmd(3'($urandom_range(0, 7)), 8'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 7) != 0) bus_cmd(MODE_STOP, 8'($urandom));
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic random_phase(input logic [HALF_W-1:0] half, input int budget);
    int target;
    set_half_ticks(half);
    target = ticks_sent + budget;
    while (ticks_sent < target) bus_transfer();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd_valid = 1'b0;
    cmd_ch.mode      = MODE_START;
    cmd_ch.tx_byte   = '0;
    cmd_ch.sda_in    = 1'b1;
    sda_kind         = SDA_RAND;
    burst_left       = 0;
    ticks_sent       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pass: a start at the reset half period, the rest at the shortest
    bus_cmd(MODE_START, 8'h00);
    set_half_ticks(16'd1);
    bus_cmd(MODE_WRITE, 8'h00);
    sda_kind = SDA_LOW;
    bus_cmd(MODE_RACK, 8'hFF);
    bus_cmd(MODE_WRITE, 8'hFF);
    sda_kind = SDA_HIGH;
    bus_cmd(MODE_RACK, 8'h00);
    bus_cmd(MODE_READ, 8'h00);
    bus_cmd(MODE_ACK, 8'hFF);
    sda_kind = SDA_LOW;
    bus_cmd(MODE_READ, 8'hFF);
    bus_cmd(MODE_NACK, 8'h00);
    sda_kind = SDA_RAND;
    bus_cmd(MODE_READ, 8'h3C);
    // unknown mode while idle starts nothing
    bus_cmd(3'd7, 8'hA5);
    send_tick(1'b1, 3'd7, 8'h5A);
    bus_cmd(MODE_STOP, 8'h00);
    bus_cmd(MODE_START, 8'hFF);
    bus_cmd(MODE_WRITE, 8'h5A);
    bus_cmd(MODE_STOP, 8'hFF);

    random_phase(16'd1, 250);
    random_phase(16'd0, 150);
    random_phase(16'd2, 100);
    random_phase(16'd3, 50);

    fill_while_busy();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
